### hw/rtl/rsi_pkg.sv
// Shared widths, operation codes and beat types for the relative strength index block.
package rsi_pkg;

  localparam int PRICE_W  = 32;
  localparam int CFG_W    = 10;
  localparam int SS_W     = CFG_W + 1;
  localparam int ACC_W    = 64;
  localparam int RSI_W    = 23;
  localparam int FRAC_W   = 16;
  localparam int CNT_W    = 7;
  localparam int DIV_STEPS = ACC_W;
  localparam int MUL_STEPS = CFG_W;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 10'd14;
  localparam logic [CFG_W-1:0] RSI_SCALE    = 10'd100;
  localparam logic [RSI_W-1:0] RSI_FULL     = 23'd6553600;

  localparam int OPC_W = 2;
  localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
  localparam logic [OPC_W-1:0] OP_MUL = 2'd1;
  localparam logic [OPC_W-1:0] OP_DIV = 2'd2;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               restart;
  } rsi_in_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi_value;
    logic             rsi_valid;
  } rsi_out_t;

  typedef struct packed {
    logic             start;
    logic [OPC_W-1:0] op;
  } alu_req_t;

endpackage

### hw/rtl/rsi_muldiv.sv
// Iterative add, shift-add multiply and restoring divide around one shared 66-bit adder.
module rsi_muldiv import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  alu_req_t         req,
  input  logic [ACC_W-1:0] opa,
  input  logic [ACC_W-1:0] opb,
  output logic [ACC_W-1:0] result,
  output logic             done
);

  logic [OPC_W-1:0] op_r, op_nxt;
  logic [ACC_W-1:0] w_r, w_nxt;
  logic [ACC_W-1:0] q_r, q_nxt;
  logic [ACC_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [ACC_W:0]   x65, y65;
  logic             sub;
  logic [ACC_W+1:0] sum;

  // Division subtracts the divisor from the shifted remainder; the carry out
  // is set when the trial subtraction does not borrow.
  always_comb begin
    case (op_r)
      OP_DIV: begin
        x65 = {w_r, q_r[ACC_W-1]};
        y65 = {1'b0, b_r};
        sub = 1'b1;
      end
      default: begin
        x65 = {1'b0, w_r};
        y65 = {1'b0, q_r};
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, x65} + {1'b0, (sub ? ~y65 : y65)} + {{(ACC_W+1){1'b0}}, sub};
  end

  always_comb begin
    op_nxt   = op_r;
    w_nxt    = w_r;
    q_nxt    = q_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      case (req.op)
        OP_ADD: begin
          w_nxt   = opa;
          q_nxt   = opb;
          cnt_nxt = CNT_W'(1);
        end
        OP_MUL: begin
          w_nxt   = '0;
          q_nxt   = opa;
          b_nxt   = opb;
          cnt_nxt = CNT_W'(MUL_STEPS);
        end
        OP_DIV: begin
          w_nxt   = '0;
          q_nxt   = opa;
          b_nxt   = opb;
          cnt_nxt = CNT_W'(DIV_STEPS);
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_ADD: begin
          w_nxt = sum[ACC_W-1:0];
        end
        OP_MUL: begin
          if (b_r[0]) begin
            w_nxt = sum[ACC_W-1:0];
          end
          q_nxt = {q_r[ACC_W-2:0], 1'b0};
          b_nxt = {1'b0, b_r[ACC_W-1:1]};
        end
        OP_DIV: begin
          if (sum[ACC_W+1]) begin
            w_nxt = sum[ACC_W-1:0];
            q_nxt = {q_r[ACC_W-2:0], 1'b1};
          end else begin
            w_nxt = x65[ACC_W-1:0];
            q_nxt = {q_r[ACC_W-2:0], 1'b0};
          end
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    q_r <= q_nxt;
    b_r <= b_nxt;
  end

  assign result = (op_r == OP_DIV) ? q_r : w_r;
  assign done   = done_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("operation started while unit busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done raised while unit still busy");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held for more than one cycle");

endmodule

### hw/rtl/relative_strength_index.sv
// Wilder relative strength index: sequencer, series state and output register.
// Per beat: a restart only loads the output, an accumulate beat issues two adds, and seed
// and smoothing beats add 64-bit divides and multiplies, all on the shared unit.
// Throughput: one beat at a time; in_stall is high from acceptance until the result
// is loaded into the output register, which can still hold the prior result meanwhile.
// Reset (synchronous, rst_n low) empties the output, sets the period to 14 and makes
// the next beat start a new series.
module relative_strength_index import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rsi_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsi_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Sequencer states. Each arithmetic state issues one operation to the shared
  // unit and waits for its done pulse.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_G_MUL = 4'd1;
  localparam logic [3:0] S_G_ADD = 4'd2;
  localparam logic [3:0] S_G_DIV = 4'd3;
  localparam logic [3:0] S_L_MUL = 4'd4;
  localparam logic [3:0] S_L_ADD = 4'd5;
  localparam logic [3:0] S_L_DIV = 4'd6;
  localparam logic [3:0] S_R_MUL = 4'd7;
  localparam logic [3:0] S_R_SUM = 4'd8;
  localparam logic [3:0] S_R_DIV = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // Phase of the series for the beat in flight.
  localparam logic [1:0] MODE_ACC    = 2'd0;
  localparam logic [1:0] MODE_SEED   = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;

  logic [3:0]         state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [CFG_W-1:0]   period_r, period_nxt;
  logic [PRICE_W-1:0] last_r, last_nxt;
  logic [SS_W-1:0]    ss_r, ss_nxt;
  logic [ACC_W-1:0]   g_r, g_nxt;
  logic [ACC_W-1:0]   l_r, l_nxt;
  logic [PRICE_W-1:0] x_r, x_nxt;
  logic [PRICE_W-1:0] y_r, y_nxt;
  logic [ACC_W-1:0]   t_r, t_nxt;
  logic [ACC_W-1:0]   d_r, d_nxt;
  rsi_out_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  rsi_out_t           out_data_r, out_data_nxt;

  logic [CFG_W-1:0]   p;
  logic [CFG_W-1:0]   p_m1;
  logic [SS_W-1:0]    p_ext;
  logic [PRICE_W-1:0] up_diff, dn_diff;

  alu_req_t           alu_req;
  logic [ACC_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_done;

  // A period of zero behaves as one.
  assign p       = (period_r == '0) ? CFG_W'(1) : period_r;
  assign p_m1    = p - CFG_W'(1);
  assign p_ext   = SS_W'(p);
  assign up_diff = in_data.price - last_r;
  assign dn_diff = last_r - in_data.price;

  // Operand routing to the shared unit. The RSI numerator is 100 * g shifted
  // into Q7.16, wrapping at 64 bits like the arithmetic it mirrors.
  always_comb begin
    alu_req.start = pend_r;
    alu_req.op    = OP_ADD;
    alu_a         = '0;
    alu_b         = '0;
    case (state_r)
      S_G_MUL: begin
        alu_req.op = OP_MUL;
        alu_a      = g_r;
        alu_b      = ACC_W'(p_m1);
      end
      S_G_ADD: begin
        alu_req.op = OP_ADD;
        alu_a      = g_r;
        alu_b      = ACC_W'(x_r);
      end
      S_G_DIV: begin
        alu_req.op = OP_DIV;
        alu_a      = g_r;
        alu_b      = ACC_W'(p);
      end
      S_L_MUL: begin
        alu_req.op = OP_MUL;
        alu_a      = l_r;
        alu_b      = ACC_W'(p_m1);
      end
      S_L_ADD: begin
        alu_req.op = OP_ADD;
        alu_a      = l_r;
        alu_b      = ACC_W'(y_r);
      end
      S_L_DIV: begin
        alu_req.op = OP_DIV;
        alu_a      = l_r;
        alu_b      = ACC_W'(p);
      end
      S_R_MUL: begin
        alu_req.op = OP_MUL;
        alu_a      = g_r;
        alu_b      = ACC_W'(RSI_SCALE);
      end
      S_R_SUM: begin
        alu_req.op = OP_ADD;
        alu_a      = g_r;
        alu_b      = l_r;
      end
      S_R_DIV: begin
        alu_req.op = OP_DIV;
        alu_a      = {t_r[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        alu_b      = d_r;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  rsi_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .result (alu_res),
    .done   (alu_done)
  );

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = 1'b0;
    mode_nxt      = mode_r;
    period_nxt    = cfg_we ? cfg_wdata : period_r;
    last_nxt      = last_r;
    ss_nxt        = ss_r;
    g_nxt         = g_r;
    l_nxt         = l_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.price;
          if (in_data.price > last_r) begin
            x_nxt = up_diff;
            y_nxt = '0;
          end else begin
            x_nxt = '0;
            y_nxt = dn_diff;
          end
          if (in_data.restart || ss_r == '0) begin
            // New series: this price only becomes the reference.
            ss_nxt    = SS_W'(1);
            g_nxt     = '0;
            l_nxt     = '0;
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else if (ss_r < p_ext) begin
            mode_nxt  = MODE_ACC;
            ss_nxt    = ss_r + SS_W'(1);
            state_nxt = S_G_ADD;
            pend_nxt  = 1'b1;
          end else if (ss_r == p_ext) begin
            mode_nxt  = MODE_SEED;
            ss_nxt    = p_ext + SS_W'(1);
            state_nxt = S_G_ADD;
            pend_nxt  = 1'b1;
          end else begin
            mode_nxt  = MODE_SMOOTH;
            ss_nxt    = p_ext + SS_W'(1);
            state_nxt = S_G_MUL;
            pend_nxt  = 1'b1;
          end
        end
      end
      S_G_MUL: begin
        if (alu_done) begin
          g_nxt     = alu_res;
          state_nxt = S_G_ADD;
          pend_nxt  = 1'b1;
        end
      end
      S_G_ADD: begin
        if (alu_done) begin
          g_nxt     = alu_res;
          state_nxt = (mode_r == MODE_ACC) ? S_L_ADD : S_G_DIV;
          pend_nxt  = 1'b1;
        end
      end
      S_G_DIV: begin
        if (alu_done) begin
          g_nxt     = alu_res;
          state_nxt = (mode_r == MODE_SMOOTH) ? S_L_MUL : S_L_ADD;
          pend_nxt  = 1'b1;
        end
      end
      S_L_MUL: begin
        if (alu_done) begin
          l_nxt     = alu_res;
          state_nxt = S_L_ADD;
          pend_nxt  = 1'b1;
        end
      end
      S_L_ADD: begin
        if (alu_done) begin
          l_nxt = alu_res;
          if (mode_r == MODE_ACC) begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_L_DIV;
            pend_nxt  = 1'b1;
          end
        end
      end
      S_L_DIV: begin
        if (alu_done) begin
          l_nxt = alu_res;
          if (alu_res == '0) begin
            // No losses at all: the index pins at full scale.
            res_nxt.rsi_value = RSI_FULL;
            res_nxt.rsi_valid = 1'b1;
            state_nxt         = S_OUT;
          end else begin
            state_nxt = S_R_MUL;
            pend_nxt  = 1'b1;
          end
        end
      end
      S_R_MUL: begin
        if (alu_done) begin
          t_nxt     = alu_res;
          state_nxt = S_R_SUM;
          pend_nxt  = 1'b1;
        end
      end
      S_R_SUM: begin
        if (alu_done) begin
          d_nxt     = alu_res;
          state_nxt = S_R_DIV;
          pend_nxt  = 1'b1;
        end
      end
      S_R_DIV: begin
        if (alu_done) begin
          res_nxt.rsi_value = alu_res[RSI_W-1:0];
          res_nxt.rsi_valid = 1'b1;
          state_nxt         = S_OUT;
        end
      end
      S_OUT: begin
        // Load the output register once it is empty or being drained.
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      mode_r      <= MODE_ACC;
      period_r    <= PERIOD_RESET;
      ss_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      mode_r      <= mode_nxt;
      period_r    <= period_nxt;
      ss_r        <= ss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    g_r        <= g_nxt;
    l_r        <= l_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_op_state: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r != S_IDLE && state_r != S_OUT))
    else $error("shared unit finished outside an arithmetic state");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && res_r.rsi_valid) |-> (ss_r == p_ext + SS_W'(1)))
    else $error("valid index with sample count short of the period");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.rsi_valid) |-> (out_data_r.rsi_value == '0))
    else $error("invalid beat carries a nonzero index");

  a_issue_once: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r) else $error("operation issued on consecutive cycles");

endmodule

### sim/rsi_beat_checker.sv
// Channel monitor, RSI predictor and result scoreboard for the relative strength index block.
`timescale 1ns / 100ps

module rsi_beat_checker import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  rsi_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  rsi_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  // Shadow copy of the series state and the period register.
  logic [CFG_W-1:0]   period_reg;
  logic [PRICE_W-1:0] prev_price;
  logic [SS_W-1:0]    seen;
  logic [ACC_W-1:0]   gain_acc;
  logic [ACC_W-1:0]   loss_acc;

  rsi_out_t rsi_expected_q[$];
  int       mismatches;

  // Advances the shadow state by one price beat and returns the RSI beat it should produce.
  function automatic rsi_out_t predict_rsi(rsi_in_t beat);
    logic [ACC_W-1:0] span;
    logic [ACC_W-1:0] up;
    logic [ACC_W-1:0] down;
    rsi_out_t         res;
    span = (period_reg == '0) ? 64'd1 : 64'(period_reg);
    up   = '0;
    down = '0;
    res  = '0;
    if (beat.restart || seen == '0) begin
      prev_price = beat.price;
      seen       = SS_W'(1);
      gain_acc   = '0;
      loss_acc   = '0;
      return res;
    end
    if (beat.price > prev_price) begin
      up = 64'(beat.price - prev_price);
    end else begin
      down = 64'(prev_price - beat.price);
    end
    prev_price = beat.price;
    if (64'(seen) < span) begin
      // Still collecting the seed sums.
      gain_acc = gain_acc + up;
      loss_acc = loss_acc + down;
      seen     = seen + 1'b1;
      return res;
    end else if (64'(seen) == span) begin
      gain_acc = (gain_acc + up) / span;
      loss_acc = (loss_acc + down) / span;
    end else begin
      gain_acc = (gain_acc * (span - 1) + up) / span;
      loss_acc = (loss_acc * (span - 1) + down) / span;
    end
    seen = SS_W'(span + 1);
    res.rsi_valid = 1'b1;
    if (loss_acc == '0) begin
      res.rsi_value = RSI_FULL;
    end else begin
      res.rsi_value = RSI_W'((64'(RSI_FULL) * gain_acc) / (gain_acc + loss_acc));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsi_out_t want;
    if (!rst_n) begin
      period_reg = PERIOD_RESET;
      prev_price = '0;
      seen       = '0;
      gain_acc   = '0;
      loss_acc   = '0;
      mismatches = 0;
      rsi_expected_q.delete();
    end else begin
      if (cfg_we) begin
        period_reg = cfg_wdata;
      end
      // The result side is checked before the new input is predicted, so a stray
      // result can never pair with an expectation created at the same edge.
      if (out_valid && !out_stall) begin
        if (rsi_expected_q.size() == 0) begin
          $error("result beat with nothing expected: rsi_value %0d rsi_valid %0b",
                 out_data.rsi_value, out_data.rsi_valid);
          mismatches++;
        end else begin
          want = rsi_expected_q.pop_front();
          if (out_data.rsi_value !== want.rsi_value) begin
            $error("rsi_value mismatch: expected %0d, got %0d",
                   want.rsi_value, out_data.rsi_value);
            mismatches++;
          end
          if (out_data.rsi_valid !== want.rsi_valid) begin
            $error("rsi_valid mismatch: expected %0b, got %0b",
                   want.rsi_valid, out_data.rsi_valid);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        rsi_expected_q.push_back(predict_rsi(in_data));
      end
    end
    pending    <= rsi_expected_q.size();
    fail_count <= mismatches;
  end

endmodule

### sim/relative_strength_index_tb.sv
// Stimulus, flow control and verdict for the relative strength index block.
`timescale 1ns / 100ps

module relative_strength_index_tb;
  import rsi_pkg::*;

  // The long receiver hold-off is the longest stretch in which no beat can move
  // on either channel.
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = 400;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  rsi_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsi_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;

  // Idle rates for the current phase, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The main process arms the long hold-off; the receiver process takes it once.
  logic hold_armed = 1'b0;
  logic hold_taken = 1'b0;

  logic [PRICE_W-1:0] walk_price = '0;
  int                 quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  relative_strength_index uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rsi_beat_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random stalls at the phase rate, plus one long hold-off when armed.
  // During the hold-off the sender keeps offering, so the block fills its two
  // stages and then has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: a run of cycles in which no beat moves on either channel means
  // the block has hung or lost a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one price beat, after a random number of idle cycles, and returns at
  // the edge where it is taken. Valid is left high so the next beat can follow
  // back to back without valid being lowered and raised in the same step.
  task automatic send_price(input logic [PRICE_W-1:0] price, input logic restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.price   <= price;
    in_data.restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted RSI beat has come back, which
  // also means the block is idle and the period register may be written.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_period(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Next price of a random walk: mostly small moves so the averages settle into
  // meaningful RSI values, with flat ticks, jumps and both rails mixed in.
  function automatic logic [PRICE_W-1:0] next_price(input logic [PRICE_W-1:0] cur);
    int                 pick;
    logic [PRICE_W-1:0] step;
    logic [PRICE_W:0]   raised;
    pick = $urandom_range(0, 99);
    step = $urandom_range(0, 32'h0004_0000);
    if (pick < 4) begin
      return $urandom;
    end else if (pick < 7) begin
      return '0;
    end else if (pick < 10) begin
      return '1;
    end else if (pick < 18) begin
      return cur;
    end else if (pick < 59) begin
      raised = {1'b0, cur} + {1'b0, step};
      return raised[PRICE_W] ? '1 : raised[PRICE_W-1:0];
    end else begin
      return (step > cur) ? '0 : cur - step;
    end
  endfunction

  // One phase of random series: the block is drained and the period written
  // first, so a new period may land in the middle of a running series.
  task automatic run_phase(input logic [CFG_W-1:0] period, input int sender_idle,
                           input int receiver_stall, input int beats,
                           input int restart_permille, input logic long_hold);
    logic restart;
    drain_results();
    write_period(period);
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    if (long_hold) begin
      hold_armed <= 1'b1;
    end
    for (int n = 0; n < beats; n++) begin
      restart = ($urandom_range(0, 999) < restart_permille);
      walk_price = restart ? $urandom : next_price(walk_price);
      send_price(walk_price, restart);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, period at its reset value of 14. The first beat after reset
    // must start a series even though its restart flag is clear.
    send_price(32'h0000_0000, 1'b0);
    // Full-scale swings: seven gains and seven losses of the largest size, then
    // one smoothing step; the seed completes on the fourteenth difference.
    for (int k = 0; k < 15; k++) begin
      send_price((k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b0);
    end

    // Period one: every difference is its own average, so gain-only and flat
    // ticks give exactly 100 (zero loss, even with zero gain) and a pure drop gives 0.
    drain_results();
    write_period(10'd1);
    send_price(32'h0000_0064, 1'b1);
    send_price(32'h0000_00C8, 1'b0);
    send_price(32'h0000_00C8, 1'b0);
    send_price(32'h0000_0032, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);

    // A period of zero behaves as one.
    drain_results();
    write_period(10'd0);
    send_price(32'hFFFF_FFFF, 1'b1);
    send_price(32'h0000_0000, 1'b0);

    // Random phases across idle patterns and periods. The largest period is
    // followed by a small one without a restart, so the series jumps straight
    // into smoothing with the partial sums as they stand.
    run_phase(10'd14,   0,  0, 250, 15, 1'b0);
    run_phase(10'd5,   66,  0, 250, 20, 1'b0);
    run_phase(10'd1023, 31, 31,  40,  0, 1'b0);
    run_phase(10'd9,    0, 66, 250, 15, 1'b0);
    run_phase(10'd2,   31, 31, 250, 20, 1'b0);
    run_phase(10'd1,   66, 66, 100, 20, 1'b0);
    run_phase(10'd20,   0,  0, 150, 10, 1'b1);

    // Let the last results drain, then watch a while longer for any stray beat.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
